FILE: src/gdc_pkg.sv
`default_nettype none

package gdc_pkg;

  // internal year range covers estimates up to the largest reachable day count
  localparam int YEAR_W = 17;
  localparam int SER_W  = 25;
  localparam int DAYS_W = 26;
  localparam int CNT_W  = 24;

  localparam int LAST_YEAR_DEF = 16383;

  localparam logic [1:0] ACT_DIFF = 2'd0;
  localparam logic [1:0] ACT_ADD  = 2'd1;
  localparam logic [1:0] ACT_WDAY = 2'd2;
  localparam logic [1:0] ACT_YDAY = 2'd3;

  // reciprocal constants: x/100 exact below 43690, x/7 exact below 2^24
  localparam logic [12:0] DIV100_K = 13'd5243;
  localparam int          DIV100_S = 19;
  localparam logic [23:0] DIV7_K   = 24'd9586981;
  localparam int          DIV7_S   = 26;
  // slightly low 1/365.2425, estimate lands within one year of the answer
  localparam logic [21:0] YEAR_K   = 22'd2939805;
  localparam int          YEAR_S   = 30;

  typedef logic [YEAR_W-1:0]        year_t;
  typedef logic [SER_W-1:0]         ser_t;
  typedef logic signed [DAYS_W-1:0] days_t;

  typedef struct packed {
    logic [1:0]       action;
    logic             neg;
    logic [CNT_W-1:0] count;
  } side_t;

  function automatic year_t div100(year_t x);
    logic [YEAR_W+12:0] p;
    p = (YEAR_W+13)'(x) * (YEAR_W+13)'(DIV100_K);
    return year_t'(p >> DIV100_S);
  endfunction

  function automatic logic is_leap(year_t y);
    year_t q;
    year_t rem;
    q   = div100(y);
    rem = y - year_t'(q * year_t'(100));
    return (y[1:0] == 2'b00) && ((rem != '0) || (q[1:0] == 2'b00));
  endfunction

  // days from year 0 Jan 1 to Jan 1 of year y
  function automatic ser_t year_start(year_t y);
    year_t q1;
    year_t q2;
    q1 = div100(y + year_t'(99));
    q2 = div100(y + year_t'(399));
    return ser_t'(y) * ser_t'(365) + ser_t'((y + year_t'(3)) >> 2)
           - ser_t'(q1) + ser_t'(q2 >> 2);
  endfunction

  // days before month index mi (0..12)
  function automatic logic [8:0] days_before(logic [3:0] mi, logic lp);
    logic [8:0] c;
    case (mi)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd31;
      4'd2:    c = 9'd59;
      4'd3:    c = 9'd90;
      4'd4:    c = 9'd120;
      4'd5:    c = 9'd151;
      4'd6:    c = 9'd181;
      4'd7:    c = 9'd212;
      4'd8:    c = 9'd243;
      4'd9:    c = 9'd273;
      4'd10:   c = 9'd304;
      4'd11:   c = 9'd334;
      default: c = 9'd365;
    endcase
    if (lp && (mi >= 4'd2)) c = c + 9'd1;
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/gdc_date_split.sv
`default_nettype none

// day count -> year, month index, day; five register stages
module gdc_date_split (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire gdc_pkg::ser_t  in_total,
  input  wire gdc_pkg::side_t in_side,
  output logic                out_valid,
  output gdc_pkg::year_t      out_year,
  output logic [3:0]          out_month_idx,
  output logic [4:0]          out_day,
  output gdc_pkg::side_t      out_side
);

  logic va_r, vb_r, vc_r, vd_r, ve_r;
  gdc_pkg::side_t sa_r, sb_r, sc_r, sd_r, se_r;
  gdc_pkg::ser_t  ta_r, tb_r, tc_r;
  gdc_pkg::year_t ea_r, eb_r, yc_r, yd_r, ye_r;
  gdc_pkg::ser_t  yse_r, yse1_r;
  logic [8:0]     rd_r;
  logic           lpd_r;
  logic [3:0]     me_r;
  logic [4:0]     de_r;

  logic [46:0]    prod_y;
  gdc_pkg::year_t e_nxt;
  gdc_pkg::year_t y_nxt;
  gdc_pkg::ser_t  ysy;
  logic [3:0]     m_nxt;
  logic [4:0]     d_nxt;

  always_comb begin
    prod_y = 47'(in_total) * 47'(gdc_pkg::YEAR_K);
    e_nxt  = gdc_pkg::year_t'(prod_y >> gdc_pkg::YEAR_S);
  end

  always_comb begin
    if (tb_r < yse_r) begin
      y_nxt = eb_r - gdc_pkg::year_t'(1);
    end else if (tb_r < yse1_r) begin
      y_nxt = eb_r;
    end else begin
      y_nxt = eb_r + gdc_pkg::year_t'(1);
    end
  end

  assign ysy = gdc_pkg::year_start(yc_r);

  always_comb begin
    m_nxt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (rd_r >= gdc_pkg::days_before(4'(k), lpd_r)) m_nxt = m_nxt + 4'd1;
    end
    d_nxt = 5'(rd_r - gdc_pkg::days_before(m_nxt, lpd_r) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    sa_r   <= in_side;
    ta_r   <= in_total;
    ea_r   <= e_nxt;
    sb_r   <= sa_r;
    tb_r   <= ta_r;
    eb_r   <= ea_r;
    yse_r  <= gdc_pkg::year_start(ea_r);
    yse1_r <= gdc_pkg::year_start(ea_r + gdc_pkg::year_t'(1));
    sc_r   <= sb_r;
    tc_r   <= tb_r;
    yc_r   <= y_nxt;
    sd_r   <= sc_r;
    yd_r   <= yc_r;
    rd_r   <= 9'(tc_r - ysy);
    lpd_r  <= gdc_pkg::is_leap(yc_r);
    se_r   <= sd_r;
    ye_r   <= yd_r;
    me_r   <= m_nxt;
    de_r   <= d_nxt;
  end

  assign out_valid     = ve_r;
  assign out_year      = ye_r;
  assign out_month_idx = me_r;
  assign out_day       = de_r;
  assign out_side      = se_r;

endmodule

`default_nettype wire

FILE: src/gregorian_date_calculator_core.sv
`default_nettype none

// Channel   Ports                                   Handshake
// request   in_action .. in_day_offset              start high, busy low at clk edge
// result    out_year .. out_status                  out_strobe high for one cycle
//
// One request enters every cycle; nine register stages, no loop: the year comes
// from a reciprocal estimate plus one compare pair, the month from a parallel
// compare against the month table.
// Synchronous active-low reset clears all valid bits; busy is high during reset
// and low from the cycle after. The receiver cannot stall, so busy never rises again.
module gregorian_date_calculator_core #(
  parameter int LAST_YEAR = gdc_pkg::LAST_YEAR_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_action,
  input  wire logic [13:0]        in_first_year,
  input  wire logic [3:0]         in_first_month,
  input  wire logic [4:0]         in_first_day,
  input  wire logic [13:0]        in_second_year,
  input  wire logic [3:0]         in_second_month,
  input  wire logic [4:0]         in_second_day,
  input  wire logic signed [23:0] in_day_offset,
  output logic                    out_strobe,
  output logic [13:0]             out_year,
  output logic [3:0]              out_month,
  output logic [4:0]              out_day,
  output logic signed [23:0]      out_count_result,
  output logic                    out_status
);

  // stage 1: accepted request
  logic              busy_r;
  logic              v1_r;
  logic [1:0]        act1_r;
  logic [13:0]       ya1_r, yb1_r;
  logic [3:0]        ma1_r, mb1_r;
  logic [4:0]        da1_r, db1_r;
  logic signed [23:0] off1_r;

  // stage 2: serial day numbers
  logic              v2_r;
  logic [1:0]        act2_r;
  gdc_pkg::days_t    sa2_r, sb2_r;
  logic [8:0]        yd2_r;

  // stage 3: counts and day total for the split
  logic              v3_r;
  gdc_pkg::side_t    side3_r;
  gdc_pkg::ser_t     tot3_r;

  // split outputs, stage 8
  logic           sp_valid;
  gdc_pkg::year_t sp_year;
  logic [3:0]     sp_month_idx;
  logic [4:0]     sp_day;
  gdc_pkg::side_t sp_side;

  // result register
  logic              strobe_r;
  logic [13:0]       year_r;
  logic [3:0]        month_r;
  logic [4:0]        day_r;
  logic [23:0]       count_r;
  logic              status_r;
  logic [13:0]       year_nxt;
  logic [3:0]        month_nxt;
  logic [4:0]        day_nxt;
  logic [23:0]       count_nxt;
  logic              status_nxt;

  wire logic accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      v1_r     <= accept;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      strobe_r <= sp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act1_r <= in_action;
      ya1_r  <= in_first_year;
      ma1_r  <= in_first_month;
      da1_r  <= in_first_day;
      yb1_r  <= in_second_year;
      mb1_r  <= in_second_month;
      db1_r  <= in_second_day;
      off1_r <= in_day_offset;
    end
  end

  // ---- stage 2: year/month adjust, year start, days before month
  logic           yneg;
  gdc_pkg::year_t ya_eff, yb_eff;
  logic [3:0]     mia, mib;
  logic           lpa, lpb;
  logic [8:0]     bma, bmb;
  gdc_pkg::days_t ysa, ysb;
  gdc_pkg::days_t sa_nxt, sb_nxt;

  always_comb begin
    yneg   = 1'b0;
    ya_eff = gdc_pkg::year_t'(ya1_r);
    yb_eff = gdc_pkg::year_t'(yb1_r);
    if (act1_r == gdc_pkg::ACT_ADD) begin
      // add: month 0 is December before, months 13..15 roll into next year
      if (ma1_r == 4'd0) begin
        yneg   = (ya1_r == 14'd0);
        ya_eff = gdc_pkg::year_t'(ya1_r) - gdc_pkg::year_t'(1);
        mia    = 4'd11;
      end else if (ma1_r >= 4'd13) begin
        ya_eff = gdc_pkg::year_t'(ya1_r) + gdc_pkg::year_t'(1);
        mia    = ma1_r - 4'd13;
      end else begin
        mia    = ma1_r - 4'd1;
      end
    end else begin
      // other actions: month 0 clamps to January, past December to full year
      if (ma1_r == 4'd0) mia = 4'd0;
      else if (ma1_r > 4'd12) mia = 4'd12;
      else mia = ma1_r - 4'd1;
    end
    if (mb1_r == 4'd0) mib = 4'd0;
    else if (mb1_r > 4'd12) mib = 4'd12;
    else mib = mb1_r - 4'd1;

    lpa = !yneg && gdc_pkg::is_leap(ya_eff);
    lpb = gdc_pkg::is_leap(yb_eff);
    bma = gdc_pkg::days_before(mia, lpa);
    bmb = gdc_pkg::days_before(mib, lpb);
    // year -1 starts 365 days before year 0
    ysa = yneg ? -gdc_pkg::days_t'(365)
               : gdc_pkg::days_t'({1'b0, gdc_pkg::year_start(ya_eff)});
    ysb = gdc_pkg::days_t'({1'b0, gdc_pkg::year_start(yb_eff)});
    sa_nxt = ysa + gdc_pkg::days_t'({1'b0, bma}) + gdc_pkg::days_t'({1'b0, da1_r});
    if (act1_r == gdc_pkg::ACT_ADD) begin
      sa_nxt = sa_nxt - gdc_pkg::days_t'(1) + gdc_pkg::days_t'(off1_r);
    end
    sb_nxt = ysb + gdc_pkg::days_t'({1'b0, bmb}) + gdc_pkg::days_t'({1'b0, db1_r});
  end

  always_ff @(posedge clk) begin
    act2_r <= act1_r;
    sa2_r  <= sa_nxt;
    sb2_r  <= sb_nxt;
    yd2_r  <= bma + 9'({4'd0, da1_r});
  end

  // ---- stage 3: difference, weekday (mod 7 by reciprocal), day total
  gdc_pkg::days_t diff;
  logic [23:0]    x7, q7, wd;
  logic [47:0]    prod7;
  gdc_pkg::side_t side_nxt;

  always_comb begin
    diff  = sa2_r - sb2_r;
    x7    = 24'(sa2_r + gdc_pkg::days_t'(4));
    prod7 = 48'(x7) * 48'(gdc_pkg::DIV7_K);
    q7    = 24'(prod7 >> gdc_pkg::DIV7_S);
    wd    = x7 - ((q7 << 3) - q7) + 24'd1;
    side_nxt.action = act2_r;
    side_nxt.neg    = sa2_r[gdc_pkg::DAYS_W-1];
    case (act2_r)
      gdc_pkg::ACT_DIFF: side_nxt.count = 24'(diff);
      gdc_pkg::ACT_WDAY: side_nxt.count = wd;
      gdc_pkg::ACT_YDAY: side_nxt.count = 24'(yd2_r);
      default:           side_nxt.count = 24'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    side3_r <= side_nxt;
    tot3_r  <= sa2_r[gdc_pkg::DAYS_W-1] ? '0 : gdc_pkg::ser_t'(sa2_r);
  end

  // ---- stages 4..8: day total back to a date
  gdc_date_split u_split (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (v3_r),
    .in_total      (tot3_r),
    .in_side       (side3_r),
    .out_valid     (sp_valid),
    .out_year      (sp_year),
    .out_month_idx (sp_month_idx),
    .out_day       (sp_day),
    .out_side      (sp_side)
  );

  // ---- stage 9: result fields
  always_comb begin
    year_nxt   = 14'd0;
    month_nxt  = 4'd0;
    day_nxt    = 5'd0;
    count_nxt  = 24'd0;
    status_nxt = 1'b0;
    if (sp_side.action == gdc_pkg::ACT_ADD) begin
      if (sp_side.neg || (sp_year > gdc_pkg::year_t'(LAST_YEAR))) begin
        status_nxt = 1'b1;
      end else begin
        year_nxt  = 14'(sp_year);
        month_nxt = sp_month_idx + 4'd1;
        day_nxt   = sp_day;
      end
    end else begin
      count_nxt = sp_side.count;
    end
  end

  always_ff @(posedge clk) begin
    year_r   <= year_nxt;
    month_r  <= month_nxt;
    day_r    <= day_nxt;
    count_r  <= count_nxt;
    status_r <= status_nxt;
  end

  assign busy             = busy_r;
  assign out_strobe       = strobe_r;
  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day          = day_r;
  assign out_count_result = $signed(count_r);
  assign out_status       = status_r;

endmodule

`default_nettype wire

FILE: src/gdc_checker.sv
`default_nettype none

module gdc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [1:0]         in_action,
  input wire logic               out_strobe,
  input wire logic [13:0]        out_year,
  input wire logic [3:0]         out_month,
  input wire logic [4:0]         out_day,
  input wire logic signed [23:0] out_count_result,
  input wire logic               out_status
);

  // every accepted beat returns a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##9 out_strobe)
    else $error("accepted beat produced no result");

  // failed add carries no date and no count
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |->
      (out_year == 14'd0 && out_month == 4'd0 && out_day == 5'd0 &&
       out_count_result == 24'sd0))
    else $error("status set with nonzero fields");

  // a produced date is well formed
  a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_month != 4'd0) |->
      (out_month <= 4'd12 && out_day != 5'd0 && !out_status &&
       out_count_result == 24'sd0))
    else $error("malformed date result");

  // weekday stays within 1..7
  a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(start && !busy && in_action == gdc_pkg::ACT_WDAY, 9)) |->
      (out_count_result >= 24'sd1 && out_count_result <= 24'sd7))
    else $error("weekday out of range");

endmodule

bind gregorian_date_calculator_core gdc_checker u_gdc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_action        (in_action),
  .out_strobe       (out_strobe),
  .out_year         (out_year),
  .out_month        (out_month),
  .out_day          (out_day),
  .out_count_result (out_count_result),
  .out_status       (out_status)
);

`default_nettype wire
